// ===== sv/mono_framebuffer_page_readout_top_macros.svh =====
// ----------------------------------------------------------------------------
// mono framebuffer page readout: assertion macros
// shared property wrappers for the checker, clocked on clk_i, off in reset
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_PAGE_READOUT_TOP_MACROS_SVH
`define MONO_FRAMEBUFFER_PAGE_READOUT_TOP_MACROS_SVH

// same-cycle implication
`define MFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg
// screen geometry, store layout, item codes and port packing constants
// ----------------------------------------------------------------------------
`default_nettype none

package mfb_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
  localparam int STORE_DEPTH = ROW_BYTES * SCREEN_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COORD_W     = 10;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 1;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_PLOT  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // byte address of the pixel at column col of row row
  function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] row,
                                                 input logic [COORD_W-1:0] col);
    int a;
    a = int'(row) * ROW_BYTES + int'(col >> 3);
    return a[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/mfb_ram.sv =====
// ----------------------------------------------------------------------------
// mfb_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/mono_framebuffer_page_readout_top.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_page_readout_top
// 1 bpp row-major framebuffer with clear, plot and page-byte readout
// ----------------------------------------------------------------------------
// One item is handled at a time; all pixel state lives in a 1024 x 8 ram with
// one write and one registered read port. After reset the block clears the
// ram, one byte per cycle, with s_axis_tready low. A clear item runs the same
// sweep; a plot reads, modifies and writes back the byte and then hands on the
// result, or goes straight to the result when it falls off screen; a page
// readout makes eight row reads through the single read port; any other item
// goes straight to the result. The result sits in an output register, so the
// next item is taken while it waits.
`default_nettype none

module mono_framebuffer_page_readout_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // tdata: pos_x[10:0], pos_y[21:11], erase[22], read_column[29:23],
  //        read_page[32:30], zero fill[39:33]
  input  wire logic [mfb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: kind[1:0]
  input  wire logic [mfb_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: page_byte[7:0]
  output logic      [mfb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: clipped[0]
  output logic      [mfb_pkg::OUT_USER_W-1:0] m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready
);

  import mfb_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_PLOT_RD,
    ST_PLOT_WR,
    ST_READ,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [ADDR_W-1:0]   sweep_q;
  logic [3:0]          rd_cnt_q;
  logic                rd_ok_q;
  logic [10:0]         x_q;
  logic [10:0]         y_q;
  logic                erase_q;
  logic [6:0]          col_q;
  logic [2:0]          page_q;
  logic [7:0]          res_byte_q;
  logic                res_clip_q;
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_clip_q;

  logic [10:0]         in_x;
  logic [10:0]         in_y;
  logic                in_clip;
  logic [COORD_W-1:0]  rd_row;
  logic                rd_ok;
  logic [ADDR_W-1:0]   plot_addr;
  logic [ADDR_W-1:0]   read_addr;
  logic [7:0]          bit_mask;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [7:0]          ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [7:0]          ram_rdata;

  assign in_x    = s_axis_tdata[10:0];
  assign in_y    = s_axis_tdata[21:11];
  assign in_clip = in_x[10] || in_y[10] ||
                   (int'($signed(in_x)) >= SCREEN_WIDTH) ||
                   (int'($signed(in_y)) >= SCREEN_HEIGHT);

  assign rd_row    = COORD_W'({page_q, rd_cnt_q[2:0]});
  assign rd_ok     = (int'(rd_row) < SCREEN_HEIGHT) && (int'(col_q) < SCREEN_WIDTH);
  assign plot_addr = pix_addr(y_q[COORD_W-1:0], x_q[COORD_W-1:0]);
  assign read_addr = pix_addr(rd_row, COORD_W'(col_q));
  assign bit_mask  = 8'(1) << x_q[2:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_q;
    ram_wdata = '0;
    ram_raddr = read_addr;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_PLOT_RD: begin
        ram_raddr = plot_addr;
      end
      ST_PLOT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = plot_addr;
        ram_wdata = erase_q ? (ram_rdata & ~bit_mask) : (ram_rdata | bit_mask);
      end
      default: begin
      end
    endcase
  end

  mfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      rd_cnt_q    <= '0;
      rd_ok_q     <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      erase_q     <= 1'b0;
      col_q       <= '0;
      page_q      <= '0;
      res_byte_q  <= '0;
      res_clip_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_clip_q  <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT, ST_CLEAR: begin
          sweep_q <= sweep_q + ADDR_W'(1);
          if (sweep_q == ADDR_W'(STORE_DEPTH - 1)) begin
            state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            x_q        <= in_x;
            y_q        <= in_y;
            erase_q    <= s_axis_tdata[22];
            col_q      <= s_axis_tdata[29:23];
            page_q     <= s_axis_tdata[32:30];
            res_byte_q <= '0;
            res_clip_q <= 1'b0;
            rd_cnt_q   <= '0;
            sweep_q    <= '0;
            unique case (s_axis_tuser)
              KIND_CLEAR: state_q <= ST_CLEAR;
              KIND_PLOT: begin
                if (in_clip) begin
                  res_clip_q <= 1'b1;
                  state_q    <= ST_DONE;
                end else begin
                  state_q <= ST_PLOT_RD;
                end
              end
              KIND_READ: state_q <= ST_READ;
              default:   state_q <= ST_DONE;
            endcase
          end
        end
        ST_PLOT_RD: state_q <= ST_PLOT_WR;
        ST_PLOT_WR: state_q <= ST_DONE;
        ST_READ: begin
          rd_ok_q  <= rd_ok;
          rd_cnt_q <= rd_cnt_q + 4'd1;
          if (rd_cnt_q != 4'd0) begin
            res_byte_q[rd_cnt_q[2:0] - 3'd1] <= rd_ok_q & ram_rdata[col_q[2:0]];
          end
          if (rd_cnt_q == 4'd8) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= res_byte_q;
            out_clip_q  <= res_clip_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_clip_q;

endmodule

`default_nettype wire

// ===== sv/mfb_checker.sv =====
// ----------------------------------------------------------------------------
// mfb_checker
// port-level assertions for the framebuffer readout block, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "mono_framebuffer_page_readout_top_macros.svh"

module mfb_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic [mfb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic [mfb_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [mfb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [mfb_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready
);

  import mfb_pkg::*;

  logic in_acc;
  logic out_stall;
  logic read_acc;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign read_acc  = in_acc && (s_axis_tuser == KIND_READ);

  // result held while stalled
  `MFB_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  // one item in flight
  `MFB_ASSERT_NEXT(a_one_item, in_acc, !s_axis_tready, "item taken while another is in work")
  // clipped plot never carries pixel data
  `MFB_ASSERT_NOW(a_clip_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "clipped result with nonzero byte")
  // readout needs eight row reads before the next item
  `MFB_ASSERT_NEXT(a_read_busy, read_acc, ##8 !s_axis_tready, "readout finished too early")

endmodule

bind mono_framebuffer_page_readout_top mfb_checker u_mfb_checker (.*);

`default_nettype wire

// ===== tb/mono_framebuffer_page_readout_top_tb.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_page_readout_top_tb
// self-checking bench: clear, plot and page-byte readout items go in on the
// input stream, and every reply is checked against a pixel-map predictor.
// Both sides idle in random bursts. One long output stall backs the block
// up, and one pause drains all replies. The tail of the run has no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mono_framebuffer_page_readout_top_tb;

  import mfb_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1050;
  localparam int QUIET_TAIL   = 120;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;

  typedef struct {
    logic [1:0]         kind;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic               erase;
    logic [6:0]         read_column;
    logic [2:0]         read_page;
    bit                 drain;
    bit                 quiet;
  } fb_cmd_t;

  typedef struct {
    logic [7:0] page_byte;
    logic       clipped;
  } fb_reply_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;

  fb_cmd_t   command_queue[$];
  fb_reply_t predicted_replies[$];
  bit        pixel_map [SCREEN_HEIGHT][SCREEN_WIDTH];

  bit in_taken;
  bit idle_en;
  int src_gap;
  int sink_gap;
  int hold_left;
  bit hold_done;
  int cycle_count;
  int error_count;
  int replies_checked;
  int n_plots, n_clipped, n_reads, n_lit_reads, n_clears, n_unused;

  mono_framebuffer_page_readout_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // pixel-map model of the store; returns the reply one item produces
  function automatic fb_reply_t apply_command(fb_cmd_t c);
    fb_reply_t r;
    int x;
    int y;
    int row;
    int col;
    r.page_byte = 8'd0;
    r.clipped   = 1'b0;
    case (c.kind)
      KIND_CLEAR: begin
        foreach (pixel_map[i, j]) pixel_map[i][j] = 1'b0;
      end
      KIND_PLOT: begin
        x = int'(c.pos_x);
        y = int'(c.pos_y);
        if (x < 0 || y < 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) begin
          r.clipped = 1'b1;
        end else begin
          pixel_map[y][x] = !c.erase;
        end
      end
      KIND_READ: begin
        col = int'(c.read_column);
        for (int n = 0; n < 8; n++) begin
          row = int'(c.read_page) * 8 + n;
          if (row < SCREEN_HEIGHT && col < SCREEN_WIDTH) r.page_byte[n] = pixel_map[row][col];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic fb_cmd_t make_cmd(logic [1:0] kind, int x, int y, logic erase,
                                       int col, int page);
    fb_cmd_t c;
    c.kind        = kind;
    c.pos_x       = 11'(x);
    c.pos_y       = 11'(y);
    c.erase       = erase;
    c.read_column = 7'(col);
    c.read_page   = 3'(page);
    c.drain       = 1'b0;
    c.quiet       = 1'b0;
    return c;
  endfunction

  // driver: one item on the input stream, changed at the falling edge
  always @(negedge clk_i) begin
    fb_cmd_t c;
    if (rst_ni && !(s_axis_tvalid && !in_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (command_queue.size() > 0 &&
                   !(command_queue[0].drain && predicted_replies.size() > 0)) begin
        c = command_queue.pop_front();
        s_axis_tdata  <= {7'd0, c.read_page, c.read_column, c.erase, c.pos_y, c.pos_x};
        s_axis_tuser  <= c.kind;
        s_axis_tvalid <= 1'b1;
        idle_en       <= !c.quiet;
        if (!c.quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 17);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (!hold_done && replies_checked >= 150) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(1, 17) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: predict on input handshakes, check on output handshakes
  always @(posedge clk_i) begin
    fb_cmd_t   c;
    fb_reply_t p;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end else if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        c.kind        = s_axis_tuser;
        c.pos_x       = s_axis_tdata[10:0];
        c.pos_y       = s_axis_tdata[21:11];
        c.erase       = s_axis_tdata[22];
        c.read_column = s_axis_tdata[29:23];
        c.read_page   = s_axis_tdata[32:30];
        p = apply_command(c);
        predicted_replies.push_back(p);
        case (c.kind)
          KIND_CLEAR: n_clears++;
          KIND_PLOT: begin
            n_plots++;
            if (p.clipped) n_clipped++;
          end
          KIND_READ: begin
            n_reads++;
            if (p.page_byte != 8'd0) n_lit_reads++;
          end
          default: n_unused++;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_replies.size() == 0) begin
          $error("unexpected reply: page_byte %0h clipped %0b", m_axis_tdata, m_axis_tuser[0]);
          error_count++;
        end else begin
          p = predicted_replies.pop_front();
          replies_checked++;
          if (m_axis_tdata !== p.page_byte) begin
            $error("page_byte mismatch: expected %0h, got %0h", p.page_byte, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tuser[0] !== p.clipped) begin
            $error("clipped mismatch: expected %0b, got %0b", p.clipped, m_axis_tuser[0]);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    fb_cmd_t c;
    int sel;
    int last_x;
    int last_y;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_CLEAR;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b1;
    idle_en       = 1'b1;
    last_x        = 0;
    last_y        = 0;

    // directed: corners, clipping on every edge, erase, unused kind, clear
    command_queue.push_back(make_cmd(KIND_READ, 0, 0, 1'b0, 0, 0));
    command_queue.push_back(make_cmd(KIND_PLOT, 0, 0, 1'b0, 127, 7));
    command_queue.push_back(make_cmd(KIND_PLOT, 127, 63, 1'b0, 0, 0));
    command_queue.push_back(make_cmd(KIND_PLOT, 127, 0, 1'b0, 0, 0));
    command_queue.push_back(make_cmd(KIND_PLOT, 0, 63, 1'b0, 0, 0));
    command_queue.push_back(make_cmd(KIND_READ, 0, 0, 1'b0, 0, 0));
    command_queue.push_back(make_cmd(KIND_READ, -1, -1, 1'b1, 127, 7));
    command_queue.push_back(make_cmd(KIND_READ, 1023, 1023, 1'b1, 127, 0));
    command_queue.push_back(make_cmd(KIND_READ, 0, 0, 1'b0, 0, 7));
    command_queue.push_back(make_cmd(KIND_PLOT, -1, 0, 1'b0, 0, 0));
    command_queue.push_back(make_cmd(KIND_PLOT, 0, -1, 1'b0, 0, 0));
    command_queue.push_back(make_cmd(KIND_PLOT, 128, 0, 1'b0, 0, 0));
    command_queue.push_back(make_cmd(KIND_PLOT, 0, 64, 1'b1, 0, 0));
    command_queue.push_back(make_cmd(KIND_PLOT, -1024, -1024, 1'b0, 0, 0));
    command_queue.push_back(make_cmd(KIND_PLOT, 1023, 1023, 1'b1, 0, 0));
    command_queue.push_back(make_cmd(KIND_PLOT, 0, 0, 1'b1, 127, 7));
    command_queue.push_back(make_cmd(KIND_READ, 0, 0, 1'b0, 0, 0));
    command_queue.push_back(make_cmd(KIND_UNUSED, -1, -1, 1'b1, 127, 7));
    command_queue.push_back(make_cmd(KIND_CLEAR, -1, -1, 1'b1, 127, 7));
    command_queue.push_back(make_cmd(KIND_READ, 0, 0, 1'b0, 127, 7));
    command_queue.push_back(make_cmd(KIND_READ, 0, 0, 1'b0, 0, 7));

    // random: mostly on-screen plots and reads aimed at drawn pixels
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      c = make_cmd(KIND_READ, $urandom_range(0, 2047), $urandom_range(0, 2047),
                   1'($urandom_range(0, 1)), $urandom_range(0, 127), $urandom_range(0, 7));
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        c.kind = KIND_CLEAR;
      end else if (sel < 5) begin
        c.kind = KIND_UNUSED;
      end else if (sel < 58) begin
        c.kind = KIND_PLOT;
        if ($urandom_range(0, 9) != 0) begin
          last_x  = $urandom_range(0, SCREEN_WIDTH - 1);
          last_y  = $urandom_range(0, SCREEN_HEIGHT - 1);
          c.pos_x = 11'(last_x);
          c.pos_y = 11'(last_y);
        end
        c.erase = ($urandom_range(0, 3) == 0);
      end else if ($urandom_range(0, 1) == 0) begin
        c.read_column = 7'(last_x);
        c.read_page   = 3'(last_y / 8);
      end
      c.drain = (i == 600);
      c.quiet = (i >= RANDOM_ITEMS - QUIET_TAIL);
      command_queue.push_back(c);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (command_queue.size() > 0 || s_axis_tvalid || predicted_replies.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("summary: %0d plots (%0d clipped), %0d reads (%0d nonzero), %0d clears,",
             n_plots, n_clipped, n_reads, n_lit_reads, n_clears);
    $display("summary: %0d unused-kind items, %0d replies checked, %0d errors",
             n_unused, replies_checked, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
